// ----- hw/rtl/pfrq_pkg.sv -----
package pfrq_pkg;

    localparam int THREADS_DEF = 64;
    localparam int LEVELS_DEF = 64;
    localparam int TID_W = 6;
    localparam int PRIO_W = 8;
    localparam int CUR_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        K_ENQUEUE = 2'd0,
        K_DEQUEUE = 2'd1,
        K_REMOVE  = 2'd2,
        K_CHECK   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [TID_W-1:0]          thread_id;
        logic signed [PRIO_W-1:0]  priority_req;
        logic                      preemptable;
        logic [CUR_W-1:0]          current_priority;
        logic                      current_none;
    } t_req;

    typedef struct packed {
        logic [TID_W-1:0] out_thread;
        logic             thread_found;
        logic             preempt;
        logic [CNT_W-1:0] queued_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_TID,
        S_READ,
        S_LINK,
        S_FIX,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/priority_fifo_run_queue_unit.sv -----
// Enqueue and remove go from S_IDLE through S_READ, S_LINK and S_FIX to S_DONE.
// The preemption check and a dequeue of an empty queue go through S_SCAN to S_DONE;
// a dequeue that pops goes S_SCAN, S_HEAD, S_TID, S_READ, S_LINK, S_FIX, S_DONE. The scan
// covers 8 levels a cycle from the top down and stops at the first set chunk. One request at
// a time; the next is taken in the cycle the result appears, once that result is not stalled.
// Reset clears the map, count, queued bits and control; the memories keep their contents.
module priority_fifo_run_queue_unit #(
    parameter int THREADS = pfrq_pkg::THREADS_DEF,
    parameter int LEVELS = pfrq_pkg::LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  pfrq_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output pfrq_pkg::t_rsp   o_rsp
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int KW = TW + 1;
    localparam int CW = $clog2(THREADS + 1);

    typedef logic [KW-1:0] t_link;

    logic [KW-1:0] m_next [THREADS];
    logic [KW-1:0] m_prev [THREADS];
    logic [LW-1:0] m_lvl  [THREADS];
    logic [KW-1:0] m_head [LEVELS];
    logic [KW-1:0] m_tail [LEVELS];

    logic [THREADS-1:0] r_inq;
    logic [LEVELS-1:0]  r_map;
    logic [CW-1:0]      r_cnt;

    pfrq_pkg::t_state r_st, n_st;
    pfrq_pkg::t_req   r_req;
    logic [TW-1:0] r_tid;
    logic [LW-1:0] r_lvl;
    logic          r_act;
    logic          r_pre;
    logic          r_found;
    logic [KW-1:0] r_p, r_n, r_h;
    logic          r_ov;
    pfrq_pkg::t_rsp r_rsp;

    logic [KW-1:0] q_next, q_prev, q_head, q_tail;
    logic [LW-1:0] q_lvl;

    logic          s_start, s_done, s_any;
    logic [LW-1:0] s_level;

    t_link NIL;
    assign NIL = KW'(THREADS);

    logic          w_acc;
    logic [LW-1:0] w_clamp;
    logic          w_tid_ok;
    logic [TW-1:0] w_tid;

    assign o_stall = (r_st != pfrq_pkg::S_IDLE) || (r_ov && i_stall);
    assign w_acc = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_rsp = r_rsp;

    assign w_tid_ok = 32'(i_req.thread_id) < THREADS;
    assign w_tid = TW'(i_req.thread_id);

    always_comb begin
        if (i_req.priority_req[pfrq_pkg::PRIO_W-1]) begin
            w_clamp = '0;
        end else if (32'(i_req.priority_req) > LEVELS - 1) begin
            w_clamp = LW'(LEVELS - 1);
        end else begin
            w_clamp = LW'(i_req.priority_req);
        end
    end

    pfrq_scan #(.LEVELS(LEVELS)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_map   (r_map),
        .o_done  (s_done),
        .o_any   (s_any),
        .o_level (s_level)
    );

    assign s_start = w_acc && (i_req.kind == pfrq_pkg::K_DEQUEUE ||
                               i_req.kind == pfrq_pkg::K_CHECK);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pfrq_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_st = s_start ? pfrq_pkg::S_SCAN : pfrq_pkg::S_READ;
                end
            end
            pfrq_pkg::S_SCAN: begin
                if (s_done) begin
                    n_st = (r_req.kind == pfrq_pkg::K_DEQUEUE && s_any) ?
                           pfrq_pkg::S_HEAD : pfrq_pkg::S_DONE;
                end
            end
            pfrq_pkg::S_HEAD: n_st = pfrq_pkg::S_TID;
            pfrq_pkg::S_TID:  n_st = pfrq_pkg::S_READ;
            pfrq_pkg::S_READ: n_st = pfrq_pkg::S_LINK;
            pfrq_pkg::S_LINK: n_st = pfrq_pkg::S_FIX;
            pfrq_pkg::S_FIX:  n_st = pfrq_pkg::S_DONE;
            pfrq_pkg::S_DONE: n_st = pfrq_pkg::S_IDLE;
            default:          n_st = pfrq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pfrq_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_inq <= '0;
            r_map <= '0;
            r_cnt <= '0;
            r_act <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                pfrq_pkg::S_IDLE: begin
                    if (w_acc) begin
                        r_req <= i_req;
                        r_tid <= w_tid;
                        r_lvl <= w_clamp;
                        r_pre <= 1'b0;
                        r_found <= 1'b0;
                        unique case (i_req.kind)
                            pfrq_pkg::K_ENQUEUE: r_act <= w_tid_ok && !r_inq[w_tid];
                            pfrq_pkg::K_REMOVE:  r_act <= w_tid_ok && r_inq[w_tid];
                            default:             r_act <= 1'b0;
                        endcase
                    end
                end
                pfrq_pkg::S_SCAN: begin
                    if (s_done) begin
                        if (r_req.kind == pfrq_pkg::K_CHECK) begin
                            r_pre <= r_req.current_none ||
                                     (r_cnt != '0 && s_any &&
                                      32'(s_level) > 32'(r_req.current_priority));
                        end else if (s_any) begin
                            r_act <= 1'b1;
                            r_lvl <= s_level;
                        end
                    end
                end
                pfrq_pkg::S_TID: begin
                    if (r_act) begin
                        r_tid <= TW'(q_head);
                        r_found <= 1'b1;
                    end
                end
                pfrq_pkg::S_LINK: begin
                    if (r_act) begin
                        if (r_req.kind == pfrq_pkg::K_ENQUEUE) begin
                            r_inq[r_tid] <= 1'b1;
                            r_map[r_lvl] <= 1'b1;
                            r_cnt <= r_cnt + 1'b1;
                            r_pre <= r_req.preemptable && (r_req.current_none ||
                                     32'(r_lvl) > 32'(r_req.current_priority));
                        end else begin
                            r_inq[r_tid] <= 1'b0;
                            if (r_cnt != '0) begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                            r_lvl <= q_lvl;
                        end
                    end
                end
                pfrq_pkg::S_FIX: begin
                    if (r_act && r_req.kind != pfrq_pkg::K_ENQUEUE) begin
                        if (r_p == NIL && r_n == NIL) begin
                            r_map[r_lvl] <= 1'b0;
                        end
                    end
                end
                pfrq_pkg::S_DONE: begin
                    r_ov <= 1'b1;
                    r_rsp.out_thread <= r_found ? pfrq_pkg::TID_W'(r_tid) : '0;
                    r_rsp.thread_found <= r_found;
                    r_rsp.preempt <= r_pre;
                    r_rsp.queued_count <= pfrq_pkg::CNT_W'(r_cnt);
                end
                default: ;
            endcase
        end
    end

    // read stage: addresses from held request
    always_ff @(posedge i_clk) begin
        q_head <= m_head[r_lvl];
        q_tail <= m_tail[r_lvl];
        q_next <= m_next[r_tid];
        q_prev <= m_prev[r_tid];
        q_lvl  <= m_lvl[r_tid];
    end

    // unlink or append in S_LINK, patch the neighbours in S_FIX
    always_ff @(posedge i_clk) begin
        if (r_st == pfrq_pkg::S_LINK && r_act) begin
            if (r_req.kind == pfrq_pkg::K_ENQUEUE) begin
                m_lvl[r_tid] <= r_lvl;
                m_next[r_tid] <= NIL;
                m_tail[r_lvl] <= KW'(r_tid);
                if (r_map[r_lvl]) begin
                    m_prev[r_tid] <= q_tail;
                    r_h <= q_tail;
                end else begin
                    m_prev[r_tid] <= NIL;
                    m_head[r_lvl] <= KW'(r_tid);
                    r_h <= NIL;
                end
            end else begin
                r_p <= q_prev;
                r_n <= q_next;
                m_next[r_tid] <= NIL;
                m_prev[r_tid] <= NIL;
            end
        end
        if (r_st == pfrq_pkg::S_FIX && r_act) begin
            if (r_req.kind == pfrq_pkg::K_ENQUEUE) begin
                if (r_h != NIL) begin
                    m_next[TW'(r_h)] <= KW'(r_tid);
                end
            end else begin
                if (r_p != NIL) begin
                    m_next[TW'(r_p)] <= r_n;
                end else begin
                    m_head[r_lvl] <= r_n;
                end
                if (r_n != NIL) begin
                    m_prev[TW'(r_n)] <= r_p;
                end else begin
                    m_tail[r_lvl] <= r_p;
                end
            end
        end
    end
endmodule

// ----- hw/rtl/pfrq_scan.sv -----
module pfrq_scan #(
    parameter int LEVELS = pfrq_pkg::LEVELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [LEVELS-1:0]         i_map,
    output logic                      o_done,
    output logic                      o_any,
    output logic [$clog2(LEVELS)-1:0] o_level
);
    localparam int LW = $clog2(LEVELS);
    localparam int CHUNK = 8;
    localparam int STEPS = (LEVELS + CHUNK - 1) / CHUNK;
    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int PADW = STEPS * CHUNK;

    logic          r_busy, n_busy;
    logic [SW-1:0] r_step, n_step;
    logic          r_any, n_any;
    logic [LW-1:0] r_level, n_level;
    logic [PADW-1:0] w_pad;
    logic [CHUNK-1:0] w_chunk;
    logic          w_hit;
    logic [2:0]    w_bit;

    assign w_pad = {{(PADW-LEVELS){1'b0}}, i_map};

    always_comb begin
        w_chunk = w_pad[r_step*CHUNK +: CHUNK];
        w_hit = |w_chunk;
        w_bit = '0;
        for (int b = 0; b < CHUNK; b++) begin
            if (w_chunk[b]) begin
                w_bit = 3'(b);
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_any = r_any;
        n_level = r_level;
        o_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = SW'(STEPS - 1);
            n_any = 1'b0;
        end else if (r_busy) begin
            if (w_hit) begin
                n_any = 1'b1;
                n_level = LW'(r_step * CHUNK + 32'(w_bit));
            end
            if (w_hit || r_step == '0) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_any <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_any <= n_any;
        end
        r_level <= n_level;
    end

    assign o_any = n_any;
    assign o_level = n_level;
endmodule

// ----- bench/priority_fifo_run_queue_unit_test.sv -----
module priority_fifo_run_queue_unit_test;

    localparam int NTHR = 64;
    localparam int NLVL = 64;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REQ_W = $bits(pfrq_pkg::t_req);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    pfrq_pkg::t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    pfrq_pkg::t_rsp o_rsp;

    priority_fifo_run_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state: one FIFO of threads per level.
    int unsigned lvl_fifo[NLVL][$];
    bit [NTHR-1:0] queued;
    logic [5:0] thr_lvl[NTHR];
    int unsigned run_count;

    pfrq_pkg::t_rsp rsp_expected[$];
    bit rsp_known[$];
    int errors = 0;
    int send_idle = 20;
    int recv_idle = 66;
    int quiet_cycles = 0;

    function automatic int best_lvl();
        for (int l = NLVL - 1; l >= 0; l--)
            if (lvl_fifo[l].size() != 0) return l;
        return -1;
    endfunction

    function automatic pfrq_pkg::t_rsp run_queue_step(pfrq_pkg::t_req r);
        pfrq_pkg::t_rsp o;
        int lvl;
        int b;
        o = '0;
        case (r.kind)
            pfrq_pkg::K_ENQUEUE: begin
                if (!queued[r.thread_id]) begin
                    if (r.priority_req < 0) lvl = 0;
                    else if (r.priority_req > NLVL - 1) lvl = NLVL - 1;
                    else lvl = r.priority_req;
                    lvl_fifo[lvl].push_back(r.thread_id);
                    thr_lvl[r.thread_id] = 6'(lvl);
                    queued[r.thread_id] = 1'b1;
                    run_count++;
                    if (r.preemptable)
                        o.preempt = r.current_none ? 1'b1 :
                                    (lvl > int'(r.current_priority));
                end
            end
            pfrq_pkg::K_DEQUEUE: begin
                b = best_lvl();
                if (b >= 0) begin
                    o.out_thread = 6'(lvl_fifo[b].pop_front());
                    o.thread_found = 1'b1;
                    queued[o.out_thread] = 1'b0;
                    run_count--;
                end
            end
            pfrq_pkg::K_REMOVE: begin
                if (queued[r.thread_id]) begin
                    lvl = thr_lvl[r.thread_id];
                    foreach (lvl_fifo[lvl][i])
                        if (lvl_fifo[lvl][i] == r.thread_id) begin
                            lvl_fifo[lvl].delete(i);
                            break;
                        end
                    queued[r.thread_id] = 1'b0;
                    run_count--;
                end
            end
            default: begin
                if (r.current_none) o.preempt = 1'b1;
                else if (run_count != 0) o.preempt = best_lvl() > int'(r.current_priority);
            end
        endcase
        o.queued_count = 7'(run_count);
        return o;
    endfunction

    function automatic pfrq_pkg::t_req make_req(pfrq_pkg::t_kind k, int tid, int prio, bit pe,
                                                int cur, bit none);
        pfrq_pkg::t_req r;
        r.kind = k;
        r.thread_id = 6'(tid);
        r.priority_req = 8'(prio);
        r.preemptable = pe;
        r.current_priority = 6'(cur);
        r.current_none = none;
        return r;
    endfunction

    task automatic send_request(pfrq_pkg::t_req r, bit has_typed, pfrq_pkg::t_rsp typed);
        pfrq_pkg::t_rsp p;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        p = run_queue_step(r);
        if (has_typed && p !== typed) begin
            $error("typed row disagrees with predictor: %h vs %h", typed, p);
            errors++;
        end
        rsp_expected.push_back(has_typed ? typed : p);
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (rsp_expected.size() == 0) begin
                    $error("response with no request pending");
                    errors++;
                end else begin
                    pfrq_pkg::t_rsp e;
                    e = rsp_expected.pop_front();
                    if (o_rsp.out_thread !== e.out_thread) begin
                        $error("out_thread expected %0d actual %0d", e.out_thread,
                            o_rsp.out_thread);
                        errors++;
                    end
                    if (o_rsp.thread_found !== e.thread_found) begin
                        $error("thread_found expected %0d actual %0d", e.thread_found,
                            o_rsp.thread_found);
                        errors++;
                    end
                    if (o_rsp.preempt !== e.preempt) begin
                        $error("preempt expected %0d actual %0d", e.preempt, o_rsp.preempt);
                        errors++;
                    end
                    if (o_rsp.queued_count !== e.queued_count) begin
                        $error("queued_count expected %0d actual %0d", e.queued_count,
                            o_rsp.queued_count);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    typedef struct {
        pfrq_pkg::t_req r;
        bit typed;
        pfrq_pkg::t_rsp e;
    } t_row;

    function automatic pfrq_pkg::t_rsp rsp_of(int th, bit f, bit p, int c);
        pfrq_pkg::t_rsp o;
        o.out_thread = 6'(th);
        o.thread_found = f;
        o.preempt = p;
        o.queued_count = 7'(c);
        return o;
    endfunction

    t_row rows[$];

    task automatic random_phase(int n);
        pfrq_pkg::t_req r;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            r = pfrq_pkg::t_req'(REQ_W'($urandom));
            if (k < 40) r.kind = pfrq_pkg::K_ENQUEUE;
            else if (k < 70) r.kind = pfrq_pkg::K_DEQUEUE;
            else if (k < 85) r.kind = pfrq_pkg::K_REMOVE;
            else r.kind = pfrq_pkg::K_CHECK;
            if ($urandom_range(3) != 0) r.priority_req = 8'($urandom_range(63));
            send_request(r, 1'b0, '0);
        end
    endtask

    initial begin
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 0, 0, 0), 1,
                         rsp_of(0, 0, 0, 0)});
        rows.push_back('{make_req(pfrq_pkg::K_CHECK, 0, 0, 0, 0, 1), 1,
                         rsp_of(0, 0, 1, 0)});
        rows.push_back('{make_req(pfrq_pkg::K_CHECK, 0, 0, 0, 63, 0), 1,
                         rsp_of(0, 0, 0, 0)});
        rows.push_back('{make_req(pfrq_pkg::K_REMOVE, 5, 0, 0, 0, 0), 1,
                         rsp_of(0, 0, 0, 0)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 63, 127, 1, 62, 0), 1,
                         rsp_of(0, 0, 1, 1)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 0, -128, 1, 0, 1), 1,
                         rsp_of(0, 0, 1, 2)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 0, 10, 1, 0, 1), 1,
                         rsp_of(0, 0, 0, 2)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 7, 63, 0, 0, 1), 1,
                         rsp_of(0, 0, 0, 3)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 8, 30, 1, 30, 0), 1,
                         rsp_of(0, 0, 0, 4)});
        rows.push_back('{make_req(pfrq_pkg::K_ENQUEUE, 9, -1, 1, 63, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_CHECK, 0, 0, 0, 63, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_CHECK, 0, 0, 0, 62, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_REMOVE, 63, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_REMOVE, 63, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 1, 63, 1), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_REMOVE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_req(pfrq_pkg::K_DEQUEUE, 0, 0, 0, 0, 0), 1,
                         rsp_of(0, 0, 0, 0)});

        run_count = 0;
        queued = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].e);
        random_phase(RANDOM_REQUESTS / 3);
        i_valid <= 1'b0;
        // hold until the queue of responses drains
        while (rsp_expected.size() != 0) @(posedge i_clk);
        send_idle = 66;
        recv_idle = 20;
        random_phase(RANDOM_REQUESTS / 3);
        send_idle = 0;
        recv_idle = 0;
        random_phase(RANDOM_REQUESTS / 3);
        i_valid <= 1'b0;

        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
